// File: design/dedup_fifo_queue_defines.svh
// Assertion macros for the dedup FIFO queue.
`ifndef DEDUP_FIFO_QUEUE_DEFINES_SVH
`define DEDUP_FIFO_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define DFQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dfq assertion failed");
`define DFQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dfq assertion failed");
`else
`define DFQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DFQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: design/dfq_pkg.sv
// Types, constants and helpers shared by the dedup FIFO queue.
package dfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_BITS  = 8;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMD_W   = 2;
  localparam int IN_W    = 8;
  localparam int READ_W  = 8;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IN_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic [READ_W-1:0]  read_value;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic wr_en;
    idx_t addr;
    val_t wdata;
  } mem_req_t;

  function automatic idx_t slot_add(idx_t base, idx_t offset);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// File: design/dfq_store.sv
// Entry store: single-port memory with registered read data.
module dfq_store import dfq_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output val_t     rdata_o
);

  val_t mem_q [QUEUE_DEPTH];
  val_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/dedup_fifo_queue.sv
// Dedup FIFO queue top level: sequencer, single compare unit and output register.
// Push scans the stored entries, one entry compared per cycle (a duplicate ends the
// scan early); pop/peek read the head entry; full/empty/unused commands go straight
// to the result. A stalled result holds the block longer.
// One item at a time; the next transfer is taken the cycle after the result is
// registered. Reset clears head, occupancy, sequencer and output valid; store not cleared.
`include "dedup_fifo_queue_defines.svh"

module dedup_fifo_queue import dfq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_RD   = 5'b00100,
    ST_TAKE = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;
  val_t             val_q, val_d;
  idx_t             head_q, head_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             cmp_v_q, cmp_v_d;
  out_t             res_q, res_d;
  out_t             out_q;
  logic             out_valid_q, out_valid_d;
  logic             in_xfer;
  logic             load_out;
  logic             match;
  mem_req_t         mem_req;
  val_t             rdata;

  dfq_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && (state_q == ST_IDLE);
  assign match      = cmp_v_q && (rdata == val_q);

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    val_d         = val_q;
    head_d        = head_q;
    occ_d         = occ_q;
    k_d           = k_q;
    cmp_v_d       = 1'b0;
    res_d         = res_q;
    load_out      = 1'b0;
    mem_req.wr_en = 1'b0;
    mem_req.addr  = slot_add(head_q, k_q[IDX_W-1:0]);
    mem_req.wdata = val_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_d             = in_data_i.cmd;
          val_d             = in_data_i.value[VALUE_BITS-1:0];
          k_d               = '0;
          res_d.read_value  = '0;
          res_d.status      = STAT_DONE;
          res_d.entry_count = COUNT_W'(occ_q);
          case (in_data_i.cmd)
            CMD_PUSH: begin
              if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
                res_d.status = STAT_FULL;
                state_d      = ST_FIN;
              end else begin
                state_d = ST_SCAN;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (occ_q == '0) begin
                res_d.status = STAT_EMPTY;
                state_d      = ST_FIN;
              end else begin
                state_d = ST_RD;
              end
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (match) begin
          res_d.status = STAT_DUP;
          state_d      = ST_FIN;
        end else if (k_q == occ_q) begin
          // tail slot equals the next scan slot
          mem_req.wr_en     = 1'b1;
          occ_d             = occ_q + CNT_W'(1);
          res_d.entry_count = COUNT_W'(occ_q + CNT_W'(1));
          state_d           = ST_FIN;
        end else begin
          cmp_v_d = 1'b1;
          k_d     = k_q + CNT_W'(1);
        end
      end
      ST_RD: begin
        mem_req.addr = head_q;
        state_d      = ST_TAKE;
      end
      ST_TAKE: begin
        res_d.read_value = READ_W'(rdata);
        if (cmd_q == CMD_POP) begin
          head_d            = slot_add(head_q, IDX_W'(1));
          occ_d             = occ_q - CNT_W'(1);
          res_d.entry_count = COUNT_W'(occ_q - CNT_W'(1));
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      occ_q       <= '0;
      k_q         <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      occ_q       <= occ_d;
      k_q         <= k_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    val_q <= val_d;
    res_q <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DFQ_ASSERT_IMP(a_occ_bound, clk_i, rst_ni, 1'b1, occ_q <= CNT_W'(QUEUE_DEPTH))
  `DFQ_ASSERT_IMP(a_wr_scan, clk_i, rst_ni, mem_req.wr_en, state_q == ST_SCAN && !match)
  `DFQ_ASSERT_NXT(a_wr_grow, clk_i, rst_ni, mem_req.wr_en, occ_q == $past(occ_q) + CNT_W'(1))
  `DFQ_ASSERT_NXT(a_load, clk_i, rst_ni, load_out, state_q == ST_IDLE && out_valid_q)

endmodule
